FILE: rtl/core/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Shared types, codes and constants for the sequencer front end, queue,
// back end and top level.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // Widths of the command and transfer payload fields.
    localparam int ACTION_W  = 3;
    localparam int CHAR_W    = 8;
    localparam int COLUMN_W  = 4;
    localparam int LINE_W    = 4;
    localparam int NUMBER_W  = 17;
    localparam int NIBBLE_W  = 4;
    localparam int US_W      = 16;
    localparam int CFG_IDX_W = 1;

    // Default depth of the queue between front and back end.
    localparam int LCDNS_QUEUE_DEPTH = 2;

    // Reset value of the per-nibble hold register.
    localparam logic [US_W-1:0] CHAR_HOLD_RESET = 16'd500;

    // Command codes carried on the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PRINT_CHAR = 3'd0,
        ACT_INIT       = 3'd1,
        ACT_CLEAR      = 3'd2,
        ACT_MOVE       = 3'd3,
        ACT_PRINT_NUM  = 3'd4
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_HIGH = 1'b0,
        CFG_CHAR_HOLD   = 1'b1
    } cfg_index_t;

    // Decoded command as it travels from the front end to the back end.
    typedef struct packed {
        action_t     kind;
        logic [7:0]  character;
        logic [7:0]  addr;
        logic [3:0]  d4;
        logic [3:0]  d3;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [3:0]  d0;
    } cmd_entry_t;

endpackage

FILE: rtl/core/lcdns_if.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer channels
// Command channel into the sequencer and transfer channel out of it, each
// with valid/ready flow control.
// ----------------------------------------------------------------------------
interface lcdns_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [lcdns_pkg::ACTION_W-1:0] action;
    logic [lcdns_pkg::CHAR_W-1:0]   character;
    logic [lcdns_pkg::COLUMN_W-1:0] column;
    logic [lcdns_pkg::LINE_W-1:0]   line;
    logic [lcdns_pkg::NUMBER_W-1:0] number;

    modport source (output valid, output action, output character, output column,
                    output line, output number, input ready);
    modport sink   (input valid, input action, input character, input column,
                    input line, input number, output ready);
endinterface

interface lcdns_xfer_if;
    logic                           valid;
    logic                           ready;
    logic                           reg_select;
    logic [lcdns_pkg::NIBBLE_W-1:0] nibble;
    logic [lcdns_pkg::US_W-1:0]     wait_before_us;
    logic [lcdns_pkg::US_W-1:0]     hold_after_us;
    logic                           last;

    modport source (output valid, output reg_select, output nibble,
                    output wait_before_us, output hold_after_us, output last,
                    input ready);
    modport sink   (input valid, input reg_select, input nibble,
                    input wait_before_us, input hold_after_us, input last,
                    output ready);
endinterface

FILE: rtl/core/lcdns_front.sv
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts command transactions, decodes them into queue entries and splits
// print-number values into decimal digits, taking no new command meanwhile.
// ----------------------------------------------------------------------------
module lcdns_front (
    input  logic                    clk,
    input  logic                    rst_n,
    lcdns_cmd_if.sink               cmd,
    input  logic                    q_full,
    output logic                    q_push,
    output lcdns_pkg::cmd_entry_t   q_data
);
    import lcdns_pkg::*;

    typedef enum logic [0:0] {
        F_IDLE = 1'b0,
        F_CONV = 1'b1
    } front_state_t;

    typedef struct packed {
        logic [3:0]          digit;
        logic [NUMBER_W-1:0] rem;
    } digit_res_t;

    // Place value of the digit produced in each conversion step.
    localparam logic [NUMBER_W-1:0] UNIT [4] =
        '{17'd10000, 17'd1000, 17'd100, 17'd10};

    // Restoring decimal step: four compare/subtract stages by 8, 4, 2, 1 units.
    function automatic digit_res_t digit_step(input logic [NUMBER_W-1:0] val,
                                              input logic [NUMBER_W-1:0] unit);
        digit_res_t          res;
        logic [NUMBER_W-1:0] w;
        res.rem   = val;
        res.digit = '0;
        for (int b = 3; b >= 0; b--)
        begin
            w = unit << b;
            if (res.rem >= w)
            begin
                res.rem      = res.rem - w;
                res.digit[b] = 1'b1;
            end
        end
        return res;
    endfunction

    front_state_t        state_reg, state_next;
    logic [1:0]          step_reg, step_next;
    logic [NUMBER_W-1:0] rem_reg, rem_next;
    logic [3:0]          d4_reg, d4_next;
    logic [3:0]          d3_reg, d3_next;
    logic [3:0]          d2_reg, d2_next;

    logic                accept;
    logic [LINE_W-1:0]   line_m1;
    digit_res_t          step_res;
    logic                known_action;

    assign cmd.ready = (state_reg == F_IDLE) && !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign line_m1   = cmd.line - LINE_W'(1);
    assign step_res  = digit_step(rem_reg, UNIT[step_reg]);

    always_comb
    begin
        known_action = (cmd.action == ACT_PRINT_CHAR) || (cmd.action == ACT_INIT) ||
                       (cmd.action == ACT_CLEAR) || (cmd.action == ACT_MOVE);
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        d4_next    = d4_reg;
        d3_next    = d3_reg;
        d2_next    = d2_reg;
        q_push     = 1'b0;

        q_data.kind      = action_t'(cmd.action);
        q_data.character = cmd.character;
        q_data.addr      = 8'h80 + {line_m1[1:0], 6'b0} + {4'b0, cmd.column};
        q_data.d4        = d4_reg;
        q_data.d3        = d3_reg;
        q_data.d2        = d2_reg;
        q_data.d1        = step_res.digit;
        q_data.d0        = step_res.rem[3:0];

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_PRINT_NUM)
                    begin
                        state_next = F_CONV;
                        step_next  = 2'd0;
                        rem_next   = cmd.number;
                    end
                    else
                    begin
                        // Unused action codes produce no transfers and are dropped.
                        q_push = known_action;
                    end
                end
            end
            F_CONV:
            begin
                q_data.kind = ACT_PRINT_NUM;
                if (step_reg != 2'd3)
                begin
                    rem_next  = step_res.rem;
                    step_next = step_reg + 2'd1;
                    case (step_reg)
                        2'd0:    d4_next = step_res.digit;
                        2'd1:    d3_next = step_res.digit;
                        default: d2_next = step_res.digit;
                    endcase
                end
                else if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d4_reg  <= d4_next;
        d3_reg  <= d3_next;
        d2_reg  <= d2_next;
    end

endmodule

FILE: rtl/core/lcdns_queue.sv
// ----------------------------------------------------------------------------
// Sequencer command queue
// Short first-in first-out buffer of decoded commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::LCDNS_QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lcdns_pkg::cmd_entry_t   push_data,
    input  logic                    pop,
    output lcdns_pkg::cmd_entry_t   pop_data,
    output logic                    full,
    output logic                    empty
);
    import lcdns_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_entry_t       entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/lcdns_back.sv
// ----------------------------------------------------------------------------
// Sequencer back end
// Walks the byte list of each queued command and emits one nibble transfer
// per cycle while the receiver takes them, through a registered output stage.
// ----------------------------------------------------------------------------
module lcdns_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [lcdns_pkg::US_W-1:0] char_hold,
    input  logic                    q_empty,
    input  lcdns_pkg::cmd_entry_t   q_data,
    output logic                    q_pop,
    lcdns_xfer_if.source            xfer
);
    import lcdns_pkg::*;

    typedef enum logic [2:0] {
        HOLD_CHAR,
        HOLD_4500,
        HOLD_110,
        HOLD_50,
        HOLD_1400
    } hold_sel_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        hold_sel_t  hold;
        logic       last_byte;
    } byte_sel_t;

    localparam logic [US_W-1:0] LEAD_WAIT_US = 16'd40000;
    localparam logic [7:0]      ADDR_LINE1   = 8'h80;
    localparam logic [7:0]      ADDR_LINE2   = 8'hC0;
    localparam logic [7:0]      ASCII_ZERO   = 8'h30;
    localparam logic [7:0]      ASCII_POINT  = 8'h2E;

    // Byte number idx of the run for one command.
    function automatic byte_sel_t byte_lookup(input cmd_entry_t c, input logic [2:0] idx);
        byte_sel_t s;
        s.rs        = 1'b0;
        s.data      = 8'h00;
        s.hold      = HOLD_CHAR;
        s.last_byte = 1'b0;
        unique case (c.kind)
            ACT_PRINT_CHAR:
            begin
                s.rs        = 1'b1;
                s.data      = c.character;
                s.last_byte = 1'b1;
            end
            ACT_INIT:
            begin
                case (idx)
                    3'd0:
                    begin
                        s.data = 8'h03;
                        s.hold = HOLD_4500;
                    end
                    3'd1:
                    begin
                        s.data = 8'h03;
                        s.hold = HOLD_110;
                    end
                    3'd2:
                    begin
                        s.data = 8'h03;
                        s.hold = HOLD_50;
                    end
                    3'd3:
                    begin
                        s.data = 8'h02;
                        s.hold = HOLD_50;
                    end
                    3'd4:    s.data = 8'h28;
                    3'd5:    s.data = 8'h0C;
                    3'd6:    s.data = 8'h01;
                    default:
                    begin
                        s.data      = 8'h06;
                        s.last_byte = 1'b1;
                    end
                endcase
            end
            ACT_CLEAR:
            begin
                if (idx == 3'd0)
                begin
                    s.data = 8'h01;
                    s.hold = HOLD_1400;
                end
                else
                begin
                    s.data      = ADDR_LINE1;
                    s.last_byte = 1'b1;
                end
            end
            ACT_MOVE:
            begin
                s.data      = c.addr;
                s.last_byte = 1'b1;
            end
            ACT_PRINT_NUM:
            begin
                s.rs = 1'b1;
                case (idx)
                    3'd0:
                    begin
                        s.rs   = 1'b0;
                        s.data = ADDR_LINE2;
                    end
                    3'd1:    s.data = ASCII_ZERO + {4'b0, c.d4};
                    3'd2:    s.data = ASCII_ZERO + {4'b0, c.d3};
                    3'd3:    s.data = ASCII_ZERO + {4'b0, c.d2};
                    3'd4:    s.data = ASCII_POINT;
                    3'd5:    s.data = ASCII_ZERO + {4'b0, c.d1};
                    default:
                    begin
                        s.data      = ASCII_ZERO + {4'b0, c.d0};
                        s.last_byte = 1'b1;
                    end
                endcase
            end
            default:
            begin
                s.last_byte = 1'b1;
            end
        endcase
        return s;
    endfunction

    cmd_entry_t         cur_reg, cur_next;
    logic               busy_reg, busy_next;
    logic [2:0]         idx_reg, idx_next;
    logic               half_reg, half_next;

    logic               valid_reg, valid_next;
    logic               rs_reg, rs_next;
    logic [NIBBLE_W-1:0] nibble_reg, nibble_next;
    logic [US_W-1:0]    wait_reg, wait_next;
    logic [US_W-1:0]    hold_reg, hold_next;
    logic               last_reg, last_next;

    byte_sel_t          sel;
    logic               advance;
    logic               emit;
    logic               run_done;
    logic [US_W-1:0]    hold_value;

    assign xfer.valid          = valid_reg;
    assign xfer.reg_select     = rs_reg;
    assign xfer.nibble         = nibble_reg;
    assign xfer.wait_before_us = wait_reg;
    assign xfer.hold_after_us  = hold_reg;
    assign xfer.last           = last_reg;

    assign sel      = byte_lookup(cur_reg, idx_reg);
    assign advance  = !valid_reg || xfer.ready;
    assign emit     = busy_reg && advance;
    assign run_done = emit && half_reg && sel.last_byte;
    assign q_pop    = !q_empty && (!busy_reg || run_done);

    always_comb
    begin
        case (sel.hold)
            HOLD_4500: hold_value = 16'd4500;
            HOLD_110:  hold_value = 16'd110;
            HOLD_50:   hold_value = 16'd50;
            HOLD_1400: hold_value = 16'd1400;
            default:   hold_value = char_hold;
        endcase
    end

    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        half_next   = half_reg;
        valid_next  = valid_reg;
        rs_next     = rs_reg;
        nibble_next = nibble_reg;
        wait_next   = wait_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;

        if (advance)
        begin
            valid_next = emit;
        end
        if (emit)
        begin
            rs_next     = sel.rs;
            nibble_next = half_reg ? sel.data[3:0] : sel.data[7:4];
            wait_next   = (cur_reg.kind == ACT_INIT && idx_reg == 3'd0 && !half_reg) ?
                          LEAD_WAIT_US : '0;
            hold_next   = hold_value;
            last_next   = half_reg && sel.last_byte;
            half_next   = !half_reg;
            if (half_reg)
            begin
                idx_next = idx_reg + 3'd1;
            end
            if (run_done)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_next  = q_data;
            busy_next = 1'b1;
            idx_next  = 3'd0;
            half_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= 3'd0;
            half_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        rs_reg     <= rs_next;
        nibble_reg <= nibble_next;
        wait_reg   <= wait_next;
        hold_reg   <= hold_next;
        last_reg   <= last_next;
    end

endmodule

FILE: rtl/core/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Turns display commands into the 4-bit bus transfers of a character LCD.
// ----------------------------------------------------------------------------
// The cmd channel takes one display command per transaction: print a
// character, initialise, clear, move the cursor or print a five-digit number.
// The xfer channel returns the run of nibble transfers for that command,
// upper nibble first, with register select, power-up wait and hold time;
// last marks the final transfer of each run. Unused action codes are
// accepted and produce no transfers.
// Commands are decoded by the front end and queued; the back end emits one
// transfer per cycle while the receiver takes them, from a registered output
// stage. A command passes through the queue and the back end's command
// register before its first transfer is registered at the output. Runs
// follow each other without a gap while the queue holds the next command;
// a command yields 2, 4, 14 or 16 transfers. Print number holds the front
// end while its digits are produced, so it can leave the output idle when
// it directly follows a short command.
// A stalled xfer receiver holds the output stage; the queue absorbs further
// commands until it fills, then cmd.ready drops. Reset empties the queue and
// the output stage and sets char_hold_reg back to 500.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = lcdns_pkg::LCDNS_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcdns_pkg::US_W-1:0]      cfg_data,
    lcdns_cmd_if.sink                       cmd,
    lcdns_xfer_if.source                    xfer
);
    import lcdns_pkg::*;

    // Hold time after each nibble of character, cursor and setup writes.
    // The enable pulse width register belongs to the external bus timer and
    // does not change any transfer field, so writes to it are taken and
    // dropped here.
    logic [US_W-1:0] char_hold_reg, char_hold_next;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    cmd_entry_t q_wr_data;
    cmd_entry_t q_rd_data;

    always_comb
    begin
        char_hold_next = char_hold_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CHAR_HOLD:   char_hold_next = cfg_data;
                CFG_ENABLE_HIGH: char_hold_next = char_hold_reg;
                default:         char_hold_next = char_hold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_hold_reg <= CHAR_HOLD_RESET;
        end
        else
        begin
            char_hold_reg <= char_hold_next;
        end
    end

    // Front end: accepts and decodes commands, splits numbers into digits.
    lcdns_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    // Decoded commands wait here so that each side can stall on its own.
    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: one nibble transfer per cycle while the receiver takes them.
    lcdns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_hold (char_hold_reg),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .xfer      (xfer)
    );

endmodule
